@@ sv/servo_pid_drive_core_defines.svh @@
// Assertion macros for the servo PID drive core.
// Included by the RTL files that carry concurrent checks; needs clk and arst_n in scope.
`ifndef SERVO_PID_DRIVE_CORE_DEFINES_SVH
`define SERVO_PID_DRIVE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spd: same-cycle check failed");
`define SPD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spd: next-cycle check failed");
`else
`define SPD_ASSERT_IMP(lbl, ante, cons)
`define SPD_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ sv/spd_pkg.sv @@
// Shared types and constants for the servo PID drive core.
// No dependencies; imported by spd_ctrl, spd_datapath and servo_pid_drive_core.
`default_nettype none
package spd_pkg;

	localparam int SAMPLE_W   = 10;
	localparam int DRIVE_MAX  = 255;
	localparam int TIME_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int OFFS_W     = 8;
	localparam int DRIVE_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int VEL_W      = 32;
	localparam int INTEG_W    = 32;

	localparam int DIFF_W     = SAMPLE_W + 1;
	localparam int DIVD_W     = SAMPLE_W + TIME_W;
	localparam int RAW_W      = DIVD_W + 1;
	localparam int DIV_CNT_W  = $clog2(DIVD_W);
	localparam int MUL_A_W    = 33;
	localparam int MUL_B_W    = 18;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int ACC_W      = 60;
	localparam int DRV_FRAC   = 24;
	localparam int MAG_W      = ACC_W - DRV_FRAC;
	localparam int TOT_W      = MAG_W + 1;

	localparam int INTEG_LO     = 5;
	localparam int INTEG_HI     = 20;
	localparam int REACH_TOL    = 3;
	localparam int STICTION_VEL = 1638;

	localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
	localparam logic signed [VEL_W-1:0] STIC_HI = VEL_W'(STICTION_VEL);
	localparam logic signed [VEL_W-1:0] STIC_LO = -STIC_HI;
	localparam logic [GAIN_W:0] WEIGHT_ONE = (GAIN_W+1)'(1) << GAIN_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PROP   = 3'd0,
		CFG_DERIV  = 3'd1,
		CFG_INTEG  = 3'd2,
		CFG_SMOOTH = 3'd3,
		CFG_OFFSET = 3'd4
	} spd_cfg_idx_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_VEL_SMOOTH,
		MUL_RAW_WEIGHT,
		MUL_DT_ERR,
		MUL_ERR_PROP,
		MUL_VEL_DERIV,
		MUL_INT_INTEG
	} spd_mul_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_LOAD,
		ACC_ADD,
		ACC_SUB
	} spd_acc_op_t;

	typedef enum logic [1:0] {
		SH_0,
		SH_8,
		SH_16
	} spd_acc_sh_t;

	typedef struct packed {
		logic         load;
		logic         div_step;
		spd_mul_sel_t mul_sel;
		spd_acc_op_t  acc_op;
		spd_acc_sh_t  acc_sh;
		logic         vel_upd;
		logic         int_upd;
		logic         out_load;
	} spd_cmd_t;

	typedef struct packed {
		logic dt_nz;
	} spd_stat_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop;
		logic [GAIN_W-1:0] deriv;
		logic [GAIN_W-1:0] integ;
		logic [GAIN_W-1:0] smooth;
		logic [OFFS_W-1:0] offset;
	} spd_cfg_t;

	typedef struct packed {
		logic [DRIVE_W-1:0] level;
		logic               rev;
		logic               reached;
	} spd_res_t;

endpackage
`default_nettype wire

@@ sv/servo_pid_drive_core.sv @@
// Servo PID drive core, top level: configuration registers, result register, sequencer, datapath.
// Depends on spd_pkg, spd_ctrl, spd_datapath and servo_pid_drive_core_defines.svh.
//
// One request (position sample, elapsed time in ms, target position) gives one result:
// drive magnitude, direction and a target-reached flag. A request with nonzero elapsed
// time goes from acceptance through a load step, a one-bit-per-cycle restoring divider
// for the Q16 velocity, then the single shared 33x18 multiplier and its accumulator
// (velocity blend, integral step, P/D/I sum), and an output step that loads the result.
// With zero elapsed time the divide and the velocity blend are skipped. One request is
// in work at a time; the next one is taken as soon as the result is loaded into the output
// register, so a result waiting on out_stall does not hold off the following request,
// only its completion.
// Configuration writes are taken at any edge with cfg_we high; write only while idle.
// Index 0 prop gain (Q8.8), 1 damping gain, 2 integral gain (Q0.16), 3 velocity smoothing
// weight (Q0.16, weight of the old value), 4 stiction offset; other indices are ignored.
`default_nettype none
`include "servo_pid_drive_core_defines.svh"
module servo_pid_drive_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [spd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [spd_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [spd_pkg::SAMPLE_W-1:0]    position_sample,
	input  wire logic [spd_pkg::TIME_W-1:0]      elapsed_time,
	input  wire logic [spd_pkg::SAMPLE_W-1:0]    target_position,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [spd_pkg::DRIVE_W-1:0]          drive_level,
	output logic                                 reverse_dir,
	output logic                                 target_reached
);
	import spd_pkg::*;

	spd_cfg_t  cfg_q;
	spd_cmd_t  cmd;
	spd_stat_t st;
	spd_res_t  res;
	logic      in_ready;
	logic      out_free;

	logic               out_valid_q;
	logic [DRIVE_W-1:0] drive_level_q;
	logic               reverse_dir_q;
	logic               target_reached_q;

	// result slot is free when empty or being taken this edge
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = !in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop   <= GAIN_W'(256);
			cfg_q.deriv  <= '0;
			cfg_q.integ  <= '0;
			cfg_q.smooth <= '0;
			cfg_q.offset <= '0;
		end else if (cfg_we) begin
			case (spd_cfg_idx_t'(cfg_index))
				CFG_PROP:   cfg_q.prop   <= cfg_data[GAIN_W-1:0];
				CFG_DERIV:  cfg_q.deriv  <= cfg_data[GAIN_W-1:0];
				CFG_INTEG:  cfg_q.integ  <= cfg_data[GAIN_W-1:0];
				CFG_SMOOTH: cfg_q.smooth <= cfg_data[GAIN_W-1:0];
				CFG_OFFSET: cfg_q.offset <= cfg_data[OFFS_W-1:0];
				default:    cfg_q        <= cfg_q;
			endcase
		end
	end

	spd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_free (out_free),
		.st       (st),
		.cmd      (cmd)
	);

	spd_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg             (cfg_q),
		.position_sample (position_sample),
		.elapsed_time    (elapsed_time),
		.target_position (target_position),
		.st              (st),
		.res             (res)
	);

	// output register: parts the result side from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			drive_level_q    <= res.level;
			reverse_dir_q    <= res.rev;
			target_reached_q <= res.reached;
		end
	end

	assign out_valid      = out_valid_q;
	assign drive_level    = drive_level_q;
	assign reverse_dir    = reverse_dir_q;
	assign target_reached = target_reached_q;

	// a waiting result is never overwritten
	`SPD_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid_q || !out_stall)
	// velocity only moves on a request with nonzero elapsed time
	`SPD_ASSERT_IMP(a_vel_needs_dt, cmd.vel_upd, st.dt_nz)
	// an accepted request keeps the block busy on the next cycle
	`SPD_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

endmodule
`default_nettype wire

@@ sv/spd_ctrl.sv @@
// Sequencer for the servo PID drive core: divide, multiply/accumulate and result steps.
// Depends on spd_pkg; drives spd_datapath through spd_cmd_t.
`default_nettype none
module spd_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              out_free,
	input  wire spd_pkg::spd_stat_t st,
	output spd_pkg::spd_cmd_t      cmd
);
	import spd_pkg::*;

	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_DIV  = 14'b00000000000010,
		S_MV1  = 14'b00000000000100,
		S_MV2  = 14'b00000000001000,
		S_WV   = 14'b00000000010000,
		S_UV   = 14'b00000000100000,
		S_MI   = 14'b00000001000000,
		S_WI   = 14'b00000010000000,
		S_UI   = 14'b00000100000000,
		S_MD1  = 14'b00001000000000,
		S_MD2  = 14'b00010000000000,
		S_MD3  = 14'b00100000000000,
		S_WD   = 14'b01000000000000,
		S_OUT  = 14'b10000000000000
	} spd_state_t;

	spd_state_t           state_q, state_n;
	logic [DIV_CNT_W-1:0] cnt_q;

	always_comb begin
		state_n      = state_q;
		in_ready     = 1'b0;
		cmd.load     = 1'b0;
		cmd.div_step = 1'b0;
		cmd.mul_sel  = MUL_NONE;
		cmd.acc_op   = ACC_NONE;
		cmd.acc_sh   = SH_0;
		cmd.vel_upd  = 1'b0;
		cmd.int_upd  = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_n  = S_DIV;
				end
			end
			S_DIV: begin
				if (!st.dt_nz) begin
					state_n = S_MI;
				end else begin
					cmd.div_step = 1'b1;
					if (cnt_q == '0) begin
						state_n = S_MV1;
					end
				end
			end
			S_MV1: begin
				cmd.mul_sel = MUL_VEL_SMOOTH;
				cmd.acc_op  = ACC_LOAD;
				state_n     = S_MV2;
			end
			S_MV2: begin
				cmd.mul_sel = MUL_RAW_WEIGHT;
				cmd.acc_op  = ACC_ADD;
				state_n     = S_WV;
			end
			S_WV: state_n = S_UV;
			S_UV: begin
				cmd.vel_upd = 1'b1;
				state_n     = S_MI;
			end
			S_MI: begin
				cmd.mul_sel = MUL_DT_ERR;
				cmd.acc_op  = ACC_LOAD;
				state_n     = S_WI;
			end
			S_WI: state_n = S_UI;
			S_UI: begin
				cmd.int_upd = 1'b1;
				state_n     = S_MD1;
			end
			S_MD1: begin
				cmd.mul_sel = MUL_ERR_PROP;
				cmd.acc_op  = ACC_LOAD;
				cmd.acc_sh  = SH_16;
				state_n     = S_MD2;
			end
			S_MD2: begin
				cmd.mul_sel = MUL_VEL_DERIV;
				cmd.acc_op  = ACC_SUB;
				state_n     = S_MD3;
			end
			S_MD3: begin
				cmd.mul_sel = MUL_INT_INTEG;
				cmd.acc_op  = ACC_ADD;
				cmd.acc_sh  = SH_8;
				state_n     = S_WD;
			end
			S_WD: state_n = S_OUT;
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_n      = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (cmd.load) begin
				cnt_q <= DIV_CNT_W'(DIVD_W - 1);
			end else if (cmd.div_step && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/spd_datapath.sv @@
// Datapath of the servo PID drive core: serial divider, shared multiplier, accumulator, state.
// Depends on spd_pkg; steered by spd_ctrl commands.
`default_nettype none
module spd_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire spd_pkg::spd_cmd_t             cmd,
	input  wire spd_pkg::spd_cfg_t             cfg,
	input  wire logic [spd_pkg::SAMPLE_W-1:0]  position_sample,
	input  wire logic [spd_pkg::TIME_W-1:0]    elapsed_time,
	input  wire logic [spd_pkg::SAMPLE_W-1:0]  target_position,
	output spd_pkg::spd_stat_t                 st,
	output spd_pkg::spd_res_t                  res
);
	import spd_pkg::*;

	// state
	logic [SAMPLE_W-1:0]       last_pos_q;
	logic signed [VEL_W-1:0]   vel_q;
	logic signed [INTEG_W-1:0] integ_q;

	// per-request operands
	logic [TIME_W-1:0]        dt_q;
	logic signed [DIFF_W-1:0] err_q;
	logic                     neg_q, win_q, near_q;

	// divider
	logic [TIME_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;

	// multiplier / accumulator
	logic signed [PROD_W-1:0] prod_s1;
	spd_acc_op_t              op_s1;
	spd_acc_sh_t              sh_s1;
	logic signed [ACC_W-1:0]  acc_q;

	// load-time arithmetic
	logic signed [DIFF_W-1:0] err_n, diff_n;
	logic [DIFF_W-1:0]        aerr_n, adiff_n;

	assign err_n   = $signed({1'b0, target_position}) - $signed({1'b0, position_sample});
	assign diff_n  = $signed({1'b0, position_sample}) - $signed({1'b0, last_pos_q});
	assign aerr_n  = err_n[DIFF_W-1] ? DIFF_W'(-err_n) : DIFF_W'(err_n);
	assign adiff_n = diff_n[DIFF_W-1] ? DIFF_W'(-diff_n) : DIFF_W'(diff_n);

	// restoring divide step
	logic [TIME_W:0] trial;
	logic            q_bit;
	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign q_bit = (trial >= {1'b0, dt_q});

	logic signed [RAW_W-1:0] raw;
	assign raw = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	// operand select for the shared multiplier
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic [GAIN_W:0]           weight;

	assign weight = WEIGHT_ONE - {1'b0, cfg.smooth};

	always_comb begin
		case (cmd.mul_sel)
			MUL_VEL_SMOOTH: begin
				mul_a = MUL_A_W'(vel_q);
				mul_b = $signed(MUL_B_W'(cfg.smooth));
			end
			MUL_RAW_WEIGHT: begin
				mul_a = MUL_A_W'(raw);
				mul_b = $signed(MUL_B_W'(weight));
			end
			MUL_DT_ERR: begin
				mul_a = $signed(MUL_A_W'(dt_q));
				mul_b = MUL_B_W'(err_q);
			end
			MUL_ERR_PROP: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = $signed(MUL_B_W'(cfg.prop));
			end
			MUL_VEL_DERIV: begin
				mul_a = MUL_A_W'(vel_q);
				mul_b = $signed(MUL_B_W'(cfg.deriv));
			end
			MUL_INT_INTEG: begin
				mul_a = MUL_A_W'(integ_q);
				mul_b = $signed(MUL_B_W'(cfg.integ));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	logic signed [ACC_W-1:0] term;
	always_comb begin
		case (sh_s1)
			SH_8:    term = ACC_W'(prod_s1) <<< 8;
			SH_16:   term = ACC_W'(prod_s1) <<< 16;
			default: term = ACC_W'(prod_s1);
		endcase
	end

	// velocity: floor of the Q16 blend, saturated
	logic signed [ACC_W-1:0] vshift;
	logic                    vovf;
	logic signed [VEL_W-1:0] vel_n;
	assign vshift = acc_q >>> GAIN_W;
	assign vovf   = !((&vshift[ACC_W-1:VEL_W-1]) || !(|vshift[ACC_W-1:VEL_W-1]));
	assign vel_n  = vovf ? (vshift[ACC_W-1] ? VEL_MIN : VEL_MAX) : vshift[VEL_W-1:0];

	// integral: saturating add of dt*err
	logic signed [INTEG_W:0]   isum;
	logic signed [INTEG_W-1:0] integ_n;
	assign isum    = (INTEG_W+1)'(integ_q) + $signed(acc_q[INTEG_W:0]);
	assign integ_n = (isum[INTEG_W] != isum[INTEG_W-1]) ?
		(isum[INTEG_W] ? VEL_MIN : VEL_MAX) : isum[INTEG_W-1:0];

	// drive magnitude
	logic [ACC_W-1:0] abs_acc;
	logic [TOT_W-1:0] tot;
	logic             slow;
	assign abs_acc = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign slow    = (vel_q >= STIC_LO) && (vel_q <= STIC_HI);
	assign tot     = {1'b0, abs_acc[ACC_W-1:DRV_FRAC]} + TOT_W'(slow ? cfg.offset : '0);

	always_comb begin
		if (tot > TOT_W'(DRIVE_MAX)) begin
			res.level = DRIVE_W'(DRIVE_MAX);
		end else begin
			res.level = tot[DRIVE_W-1:0];
		end
		res.rev     = acc_q[ACC_W-1];
		res.reached = near_q;
	end

	assign st.dt_nz = (dt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= '0;
			vel_q      <= '0;
			integ_q    <= '0;
			op_s1      <= ACC_NONE;
		end else begin
			op_s1 <= cmd.acc_op;
			if (cmd.load) begin
				last_pos_q <= position_sample;
			end
			if (cmd.vel_upd) begin
				vel_q <= vel_n;
			end
			if (cmd.int_upd) begin
				integ_q <= win_q ? integ_n : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		sh_s1   <= cmd.acc_sh;
		prod_s1 <= mul_p;
		if (cmd.load) begin
			dt_q   <= elapsed_time;
			err_q  <= err_n;
			neg_q  <= diff_n[DIFF_W-1];
			win_q  <= (aerr_n > DIFF_W'(INTEG_LO)) && (aerr_n < DIFF_W'(INTEG_HI));
			near_q <= (aerr_n <= DIFF_W'(REACH_TOL));
			rem_q  <= '0;
			quo_q  <= {adiff_n[SAMPLE_W-1:0], TIME_W'(0)};
		end else if (cmd.div_step) begin
			rem_q <= q_bit ? TIME_W'(trial - {1'b0, dt_q}) : trial[TIME_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], q_bit};
		end
		case (op_s1)
			ACC_LOAD: acc_q <= term;
			ACC_ADD:  acc_q <= acc_q + term;
			ACC_SUB:  acc_q <= acc_q - term;
			default:  acc_q <= acc_q;
		endcase
	end

endmodule
`default_nettype wire
